@@ rtl/tdau_pkg.sv @@
// Shared widths, constants, codes and payload types of the time-of-day arithmetic unit.
package tdau_pkg;

    localparam int MODE_W = 2;
    localparam int HOUR_W = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OFFSET_W = 31;
    localparam int SEC_W = 17;
    localparam int DUR_W = 17;
    localparam int RED_W = 18;
    localparam int REM_W = 12;

    localparam int DAY_SECONDS = 86400;
    localparam int SECONDS_PER_HOUR = 3600;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MAX_HOUR = 23;
    localparam int MAX_MINUTE = 59;
    localparam int MAX_SECOND = 59;

    // A day is 675 * 2**7 seconds, so the offset quotient is taken on offset >> 7.
    localparam int OFF_SHIFT = 7;
    localparam int OFF_ODD = DAY_SECONDS >> OFF_SHIFT;
    localparam int OFF_X_W = OFFSET_W - OFF_SHIFT;
    localparam int OFF_K = 34;
    localparam int OFF_RECIP_W = 25;
    localparam int OFF_PROD_W = OFF_X_W + OFF_RECIP_W;
    localparam int Q_W = 15;
    localparam logic [OFF_RECIP_W-1:0] OFF_RECIP =
        OFF_RECIP_W'((64'd1 << OFF_K) / OFF_ODD);

    localparam int HOUR_K = 17;
    localparam int HOUR_RECIP_W = 6;
    localparam int HOUR_PROD_W = SEC_W + HOUR_RECIP_W;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
        HOUR_RECIP_W'((64'd1 << HOUR_K) / SECONDS_PER_HOUR);

    localparam int MIN_K = 12;
    localparam int MIN_RECIP_W = 7;
    localparam int MIN_PROD_W = REM_W + MIN_RECIP_W;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
        MIN_RECIP_W'((64'd1 << MIN_K) / SECONDS_PER_MINUTE);

    typedef enum logic [MODE_W-1:0] {
        MODE_FORWARD  = 2'd0,
        MODE_BACKWARD = 2'd1,
        MODE_DURATION = 2'd2,
        MODE_CONVERT  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HOUR_W-1:0]   hour_a;
        logic [MINUTE_W-1:0] minute_a;
        logic [SECOND_W-1:0] second_a;
        logic [HOUR_W-1:0]   hour_b;
        logic [MINUTE_W-1:0] minute_b;
        logic [SECOND_W-1:0] second_b;
        logic [OFFSET_W-1:0] offset_seconds;
    } tdau_req_t;

    typedef struct packed {
        mode_t            mode;
        logic [SEC_W-1:0] a_seconds;
        logic             a_valid;
        logic             a_equal_b;
        logic             a_less_b;
        logic             a_greater_b;
    } tdau_side_t;

    typedef struct packed {
        tdau_side_t       side;
        logic [SEC_W-1:0] t_sec;
        logic [DUR_W-1:0] duration;
    } tdau_tod_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_out;
        logic [MINUTE_W-1:0] minute_out;
        logic [SECOND_W-1:0] second_out;
        logic [DUR_W-1:0]    duration;
        logic [SEC_W-1:0]    a_seconds;
        logic                a_valid;
        logic                a_equal_b;
        logic                a_less_b;
        logic                a_greater_b;
    } tdau_res_t;

    function automatic logic [SEC_W-1:0] to_seconds(
        input logic [HOUR_W-1:0]   h,
        input logic [MINUTE_W-1:0] m,
        input logic [SECOND_W-1:0] s
    );
        logic [SEC_W-1:0] h_part;
        logic [SEC_W-1:0] m_part;
        h_part = SEC_W'(SEC_W'(h) * SEC_W'(SECONDS_PER_HOUR));
        m_part = SEC_W'(SEC_W'(m) * SEC_W'(SECONDS_PER_MINUTE));
        return SEC_W'(h_part + m_part + SEC_W'(s));
    endfunction

endpackage

@@ rtl/tdau_if.sv @@
// Valid/ready channel interfaces for the request and result transactions.
interface tdau_in_if;
    import tdau_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [HOUR_W-1:0]   hour_a;
    logic [MINUTE_W-1:0] minute_a;
    logic [SECOND_W-1:0] second_a;
    logic [HOUR_W-1:0]   hour_b;
    logic [MINUTE_W-1:0] minute_b;
    logic [SECOND_W-1:0] second_b;
    logic [OFFSET_W-1:0] offset_seconds;

    modport source (
        output valid, mode, hour_a, minute_a, second_a,
        output hour_b, minute_b, second_b, offset_seconds,
        input  ready
    );

    modport sink (
        input  valid, mode, hour_a, minute_a, second_a,
        input  hour_b, minute_b, second_b, offset_seconds,
        output ready
    );
endinterface

interface tdau_out_if;
    import tdau_pkg::*;

    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;
    logic [DUR_W-1:0]    duration;
    logic [SEC_W-1:0]    a_seconds;
    logic                a_valid;
    logic                a_equal_b;
    logic                a_less_b;
    logic                a_greater_b;

    modport source (
        output valid, hour_out, minute_out, second_out, duration,
        output a_seconds, a_valid, a_equal_b, a_less_b, a_greater_b,
        input  ready
    );

    modport sink (
        input  valid, hour_out, minute_out, second_out, duration,
        input  a_seconds, a_valid, a_equal_b, a_less_b, a_greater_b,
        output ready
    );
endinterface

@@ rtl/tdau_reduce.sv @@
// Front pipeline: seconds of day, modulo-day reduction and the mode arithmetic.
module tdau_reduce (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tdau_pkg::tdau_req_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdau_pkg::tdau_tod_t  out_data
);
    import tdau_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic [SEC_W-1:0]       a_next;
    logic [SEC_W-1:0]       b_next;
    logic [OFF_PROD_W-1:0]  q_prod;
    tdau_side_t             side1_next;
    logic [SEC_W-1:0]       s1_a_reg;
    logic [SEC_W-1:0]       s1_b_reg;
    logic [Q_W-1:0]         s1_q_reg;
    logic [OFFSET_W-1:0]    s1_off_reg;
    tdau_side_t             s1_side_reg;

    logic [SEC_W-1:0]       ar_next;
    logic [SEC_W-1:0]       br_next;
    logic [OFFSET_W-1:0]    r0_full;
    tdau_side_t             side2_next;
    logic [SEC_W-1:0]       s2_ar_reg;
    logic [SEC_W-1:0]       s2_br_reg;
    logic [RED_W-1:0]       s2_r0_reg;
    tdau_side_t             s2_side_reg;

    logic [SEC_W-1:0]       offr_next;
    logic [SEC_W-1:0]       s3_ar_reg;
    logic [SEC_W-1:0]       s3_br_reg;
    logic [SEC_W-1:0]       s3_offr_reg;
    tdau_side_t             s3_side_reg;

    logic [SEC_W-1:0]       lhs;
    logic [SEC_W-1:0]       rhs;
    logic                   sub_sel;
    logic [RED_W-1:0]       sum;
    logic [SEC_W-1:0]       wrapped;
    tdau_tod_t              tod_next;
    tdau_tod_t              tod_reg;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = tod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: seconds of A and B, and the estimated number of whole days in the offset.
    always_comb
    begin
        a_next = to_seconds(in_data.hour_a, in_data.minute_a, in_data.second_a);
        b_next = to_seconds(in_data.hour_b, in_data.minute_b, in_data.second_b);
        q_prod = OFF_PROD_W'(in_data.offset_seconds[OFFSET_W-1:OFF_SHIFT])
               * OFF_PROD_W'(OFF_RECIP);
        side1_next.mode      = mode_t'(in_data.mode);
        side1_next.a_seconds = a_next;
        side1_next.a_valid   = (in_data.hour_a <= HOUR_W'(MAX_HOUR))
                            && (in_data.minute_a <= MINUTE_W'(MAX_MINUTE))
                            && (in_data.second_a <= SECOND_W'(MAX_SECOND));
        side1_next.a_equal_b = (in_data.hour_a == in_data.hour_b)
                            && (in_data.minute_a == in_data.minute_b)
                            && (in_data.second_a == in_data.second_b);
        side1_next.a_less_b    = 1'b0;
        side1_next.a_greater_b = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_a_reg    <= a_next;
            s1_b_reg    <= b_next;
            s1_q_reg    <= q_prod[OFF_K +: Q_W];
            s1_off_reg  <= in_data.offset_seconds;
            s1_side_reg <= side1_next;
        end
    end

    // Stage 2: reduce A and B into one day, take the day count out of the offset, compare.
    always_comb
    begin
        ar_next = (s1_a_reg >= SEC_W'(DAY_SECONDS)) ? SEC_W'(s1_a_reg - SEC_W'(DAY_SECONDS))
                                                    : s1_a_reg;
        br_next = (s1_b_reg >= SEC_W'(DAY_SECONDS)) ? SEC_W'(s1_b_reg - SEC_W'(DAY_SECONDS))
                                                    : s1_b_reg;
        r0_full = OFFSET_W'(s1_off_reg - OFFSET_W'(OFFSET_W'(s1_q_reg)
                                                  * OFFSET_W'(DAY_SECONDS)));
        side2_next             = s1_side_reg;
        side2_next.a_less_b    = s1_a_reg < s1_b_reg;
        side2_next.a_greater_b = s1_a_reg > s1_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_ar_reg   <= ar_next;
            s2_br_reg   <= br_next;
            s2_r0_reg   <= r0_full[RED_W-1:0];
            s2_side_reg <= side2_next;
        end
    end

    // Stage 3: the day-count estimate may be one short, so the remainder gets one correction.
    always_comb
    begin
        if (s2_r0_reg >= RED_W'(DAY_SECONDS))
        begin
            offr_next = SEC_W'(s2_r0_reg - RED_W'(DAY_SECONDS));
        end
        else
        begin
            offr_next = s2_r0_reg[SEC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_ar_reg   <= s2_ar_reg;
            s3_br_reg   <= s2_br_reg;
            s3_offr_reg <= offr_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    // Stage 4: shift, duration or conversion, wrapped into one day.
    always_comb
    begin
        lhs     = s3_ar_reg;
        rhs     = s3_offr_reg;
        sub_sel = 1'b0;
        case (s3_side_reg.mode)
            MODE_FORWARD:
            begin
                lhs     = s3_ar_reg;
                rhs     = s3_offr_reg;
                sub_sel = 1'b0;
            end
            MODE_BACKWARD:
            begin
                lhs     = s3_ar_reg;
                rhs     = s3_offr_reg;
                sub_sel = 1'b1;
            end
            MODE_DURATION:
            begin
                lhs     = s3_br_reg;
                rhs     = s3_ar_reg;
                sub_sel = 1'b1;
            end
            default:
            begin
                lhs     = s3_ar_reg;
                rhs     = s3_offr_reg;
                sub_sel = 1'b0;
            end
        endcase

        if (sub_sel)
        begin
            sum = RED_W'(RED_W'(lhs) + RED_W'(DAY_SECONDS) - RED_W'(rhs));
        end
        else
        begin
            sum = RED_W'(RED_W'(lhs) + RED_W'(rhs));
        end
        if (sum >= RED_W'(DAY_SECONDS))
        begin
            wrapped = SEC_W'(sum - RED_W'(DAY_SECONDS));
        end
        else
        begin
            wrapped = sum[SEC_W-1:0];
        end

        tod_next.side     = s3_side_reg;
        tod_next.t_sec    = '0;
        tod_next.duration = '0;
        case (s3_side_reg.mode)
            MODE_DURATION: tod_next.duration = DUR_W'(wrapped);
            MODE_CONVERT:  tod_next.t_sec    = s3_offr_reg;
            default:       tod_next.t_sec    = wrapped;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            tod_reg <= tod_next;
        end
    end

endmodule

@@ rtl/tdau_split.sv @@
// Back pipeline: splits a time of day in seconds into hour, minute and second.
module tdau_split (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tdau_pkg::tdau_tod_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tdau_pkg::tdau_res_t  out_data
);
    import tdau_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic [HOUR_PROD_W-1:0] h_prod;
    logic [SEC_W-1:0]       s5_t_reg;
    logic [HOUR_W-1:0]      s5_h0_reg;
    tdau_side_t             s5_side_reg;
    logic [DUR_W-1:0]       s5_dur_reg;

    logic [SEC_W-1:0]       rem0;
    logic [HOUR_W-1:0]      h_next;
    logic [REM_W-1:0]       rem_next;
    logic [HOUR_W-1:0]      s6_h_reg;
    logic [REM_W-1:0]       s6_rem_reg;
    tdau_side_t             s6_side_reg;
    logic [DUR_W-1:0]       s6_dur_reg;

    logic [MIN_PROD_W-1:0]  m_prod;
    logic [HOUR_W-1:0]      s7_h_reg;
    logic [REM_W-1:0]       s7_rem_reg;
    logic [MINUTE_W-1:0]    s7_m0_reg;
    tdau_side_t             s7_side_reg;
    logic [DUR_W-1:0]       s7_dur_reg;

    logic [REM_W-1:0]       s0;
    tdau_res_t              res_next;
    tdau_res_t              res_reg;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 5: hour estimate by reciprocal multiplication; it is exact or one short.
    assign h_prod = HOUR_PROD_W'(in_data.t_sec) * HOUR_PROD_W'(HOUR_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s5_t_reg    <= in_data.t_sec;
            s5_h0_reg   <= h_prod[HOUR_K +: HOUR_W];
            s5_side_reg <= in_data.side;
            s5_dur_reg  <= in_data.duration;
        end
    end

    // Stage 6: seconds within the hour, with the hour corrected.
    always_comb
    begin
        rem0 = SEC_W'(s5_t_reg - SEC_W'(SEC_W'(s5_h0_reg) * SEC_W'(SECONDS_PER_HOUR)));
        if (rem0 >= SEC_W'(SECONDS_PER_HOUR))
        begin
            h_next   = HOUR_W'(s5_h0_reg + HOUR_W'(1));
            rem_next = REM_W'(rem0 - SEC_W'(SECONDS_PER_HOUR));
        end
        else
        begin
            h_next   = s5_h0_reg;
            rem_next = rem0[REM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s6_h_reg    <= h_next;
            s6_rem_reg  <= rem_next;
            s6_side_reg <= s5_side_reg;
            s6_dur_reg  <= s5_dur_reg;
        end
    end

    // Stage 7: minute estimate by reciprocal multiplication.
    assign m_prod = MIN_PROD_W'(s6_rem_reg) * MIN_PROD_W'(MIN_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s7_h_reg    <= s6_h_reg;
            s7_rem_reg  <= s6_rem_reg;
            s7_m0_reg   <= m_prod[MIN_K +: MINUTE_W];
            s7_side_reg <= s6_side_reg;
            s7_dur_reg  <= s6_dur_reg;
        end
    end

    // Stage 8: seconds within the minute, minute corrected, result assembled.
    always_comb
    begin
        s0 = REM_W'(s7_rem_reg - REM_W'(REM_W'(s7_m0_reg) * REM_W'(SECONDS_PER_MINUTE)));
        res_next.hour_out = s7_h_reg;
        if (s0 >= REM_W'(SECONDS_PER_MINUTE))
        begin
            res_next.minute_out = MINUTE_W'(s7_m0_reg + MINUTE_W'(1));
            res_next.second_out = SECOND_W'(s0 - REM_W'(SECONDS_PER_MINUTE));
        end
        else
        begin
            res_next.minute_out = s7_m0_reg;
            res_next.second_out = s0[SECOND_W-1:0];
        end
        res_next.duration    = s7_dur_reg;
        res_next.a_seconds   = s7_side_reg.a_seconds;
        res_next.a_valid     = s7_side_reg.a_valid;
        res_next.a_equal_b   = s7_side_reg.a_equal_b;
        res_next.a_less_b    = s7_side_reg.a_less_b;
        res_next.a_greater_b = s7_side_reg.a_greater_b;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/time_of_day_arithmetic_unit_top.sv @@
// Top level of the time-of-day arithmetic unit: shifts, durations and conversions in h:m:s.
// Throughput: one transaction per cycle; the eight-stage pipeline stalls only on result backpressure.
// The reciprocal multiplies for the day, hour and minute splits set the stage depth.
// Reset clears every stage valid bit at once; data registers are not reset.
module time_of_day_arithmetic_unit_top (
    input  logic         clk,
    input  logic         rst_n,
    tdau_in_if.sink      request,
    tdau_out_if.source   result
);
    import tdau_pkg::*;

    tdau_req_t req;
    tdau_tod_t tod;
    tdau_res_t res;
    logic      tod_valid;
    logic      tod_ready;

    always_comb
    begin
        req.mode           = request.mode;
        req.hour_a         = request.hour_a;
        req.minute_a       = request.minute_a;
        req.second_a       = request.second_a;
        req.hour_b         = request.hour_b;
        req.minute_b       = request.minute_b;
        req.second_b       = request.second_b;
        req.offset_seconds = request.offset_seconds;
    end

    tdau_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_data   (req),
        .out_valid (tod_valid),
        .out_ready (tod_ready),
        .out_data  (tod)
    );

    tdau_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tod_valid),
        .in_ready  (tod_ready),
        .in_data   (tod),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res)
    );

    assign result.hour_out    = res.hour_out;
    assign result.minute_out  = res.minute_out;
    assign result.second_out  = res.second_out;
    assign result.duration    = res.duration;
    assign result.a_seconds   = res.a_seconds;
    assign result.a_valid     = res.a_valid;
    assign result.a_equal_b   = res.a_equal_b;
    assign result.a_less_b    = res.a_less_b;
    assign result.a_greater_b = res.a_greater_b;

endmodule
